// ===== sv/kct_pkg.sv =====
`default_nettype none

package kct_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic load;      // take the input item into the working registers
    logic search;    // step the key scan by one entry
    logic read_cnt;  // read the counter at the scan position
    logic commit;    // write back and load the result register
  } kct_cmd_t;

  typedef struct packed {
    logic hit;       // compared entry holds the key
    logic exhausted; // every occupied entry compared without a hit
  } kct_stat_t;

endpackage

`default_nettype wire

// ===== sv/kct_ctrl.sv =====
`default_nettype none

module kct_ctrl
  import kct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire kct_stat_t st,
  output kct_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_WRITE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.load     = in_valid && (state == S_IDLE);
    cmd.search   = (state == S_SEARCH) && !st.hit && !st.exhausted;
    cmd.read_cnt = (state == S_READ);
    // result register must be free, or emptying this cycle
    cmd.commit   = (state == S_WRITE) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (st.hit || st.exhausted) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/kct_datapath.sv =====
`default_nettype none

module kct_datapath
  import kct_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire kct_cmd_t    cmd,
  output kct_stat_t        st,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic [1:0]       status,
  output logic [31:0]      count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0] key_mem [ENTRIES];
  logic [31:0] cnt_mem [ENTRIES];

  logic [1:0]    op_q;
  logic [31:0]   key_q;
  logic [31:0]   val_q;
  logic [CW-1:0] idx;
  logic [CW-1:0] occ;
  logic          rd_valid;
  logic [IW-1:0] rd_idx;
  logic [31:0]   key_rd;
  logic [31:0]   cnt_rd;

  logic          in_range;
  logic          is_get;
  logic          full;
  logic          cnt_we;
  logic [IW-1:0] cnt_waddr;
  logic [31:0]   cnt_wdata;
  logic          ins_en;
  logic [1:0]    status_next;
  logic [31:0]   count_next;

  assign in_range     = (idx < occ);
  assign st.hit       = rd_valid && (key_rd == key_q);
  assign st.exhausted = !rd_valid && !in_range;

  always_comb begin
    is_get      = !((op_q == OP_ADD) || (op_q == OP_SET));
    full        = (occ == CW'(ENTRIES));
    cnt_we      = 1'b0;
    ins_en      = 1'b0;
    cnt_waddr   = rd_idx;
    cnt_wdata   = val_q;
    status_next = ST_OK;
    count_next  = '0;
    if (is_get) begin
      if (st.hit) begin
        count_next = cnt_rd;
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end else if (st.hit) begin
      cnt_we = cmd.commit;
      if (op_q == OP_ADD) cnt_wdata = cnt_rd + val_q;
    end else if (!full) begin
      // miss: claim the next free entry at the end of the occupied prefix
      ins_en    = cmd.commit;
      cnt_we    = cmd.commit;
      cnt_waddr = occ[IW-1:0];
    end else begin
      status_next = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.search) begin
        rd_valid <= in_range;
        if (in_range) idx <= idx + CW'(1);
      end
      if (ins_en) occ <= occ + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      key_q <= key;
      val_q <= value;
    end
    if (cmd.search && in_range) rd_idx <= idx[IW-1:0];
    if (cmd.commit) begin
      status <= status_next;
      count  <= count_next;
    end
  end

  // key store
  always_ff @(posedge clk) begin
    if (ins_en) key_mem[occ[IW-1:0]] <= key_q;
    if (cmd.search && in_range) key_rd <= key_mem[idx[IW-1:0]];
  end

  // counter store
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd.read_cnt) cnt_rd <= cnt_mem[rd_idx];
  end

endmodule

`default_nettype wire

// ===== sv/keyed_counter_table_top.sv =====
// Table of ENTRIES 32-bit counters keyed by a 32-bit id. Add and set update
// a matching entry or claim the next free one (status full when none is
// left); get returns the counter or not-found with a zero count. One result
// per item. The keys sit in a single-port memory that is scanned one entry
// per clock, so the scan stops at the matching entry on a hit and runs over
// every occupied entry on a miss, and the next item is accepted only after
// the current one commits; the counter update is a read then a write of the
// counter memory. The table is empty straight after reset, with no
// clearing pass. A new item may be taken while the previous result waits.
`default_nettype none

module keyed_counter_table_top
  import kct_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      count
);

  kct_cmd_t  cmd;
  kct_stat_t st;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  kct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .operation (operation),
    .key       (key),
    .value     (value),
    .status    (status),
    .count     (count)
  );

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  a_ready_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> in_ready)
    else $error("not ready for an item after commit");

  a_zero_count_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (count == '0))
    else $error("non-zero count with error status");

  a_hit_excl_exhausted: assert property (@(posedge clk) disable iff (rst)
    !(st.hit && st.exhausted))
    else $error("hit and exhausted together");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import kct_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  // get is selected by the high operation bit, so both upper codes read
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_GET_HI = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_ADD;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] count;

  // shadow copy of the table
  logic [31:0] shadow_key [ENTRIES];
  logic [31:0] shadow_cnt [ENTRIES];
  int          shadow_used = 0;
  tally_t      pending_tallies[$];
  logic [31:0] key_pool [40];

  int fail_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  keyed_counter_table_top #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .count(count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15ms;
    $display("** keyed_counter_table_top: FAILED **");
    $finish;
  end

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < shadow_used; i++)
      if (shadow_key[i] == k) return i;
    return -1;
  endfunction

  function automatic tally_t update_tally(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    int     pos;
    tally_t r;
    pos = find_slot(k);
    r.status = ST_OK;
    r.count = '0;
    if (op == OP_GET || op == OP_GET_HI) begin
      if (pos >= 0) r.count = shadow_cnt[pos];
      else r.status = ST_NOT_FOUND;
    end else if (pos >= 0) begin
      if (op == OP_ADD) shadow_cnt[pos] = shadow_cnt[pos] + v;
      else shadow_cnt[pos] = v;
    end else if (shadow_used < ENTRIES) begin
      shadow_key[shadow_used] = k;
      shadow_cnt[shadow_used] = v;
      shadow_used++;
    end else begin
      r.status = ST_FULL;
    end
    return r;
  endfunction

  // mostly back-to-back, now and then a long gap
  function automatic int pick_idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_ADD;
    if (r < 60) return OP_SET;
    if (r < 90) return OP_GET;
    return OP_GET_HI;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = pick_idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_tallies.push_back(update_tally(op, k, v));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    tally_t exp;
    if (!rst && out_valid && out_ready) begin
      if (pending_tallies.size() == 0) begin
        report_error($sformatf("unexpected result status=%0d count=%h", status, count));
      end else begin
        exp = pending_tallies.pop_front();
        if (status !== exp.status)
          report_error($sformatf("status exp %0d got %0d", exp.status, status));
        if (count !== exp.count)
          report_error($sformatf("count exp %h got %h", exp.count, count));
      end
    end
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = pick_idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed_basics();
    send_item(OP_GET, 32'h0, 32'h0);                  // get on empty table
    send_item(OP_GET_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'h0, 32'hFFFF_FFFF);          // insert through add
    send_item(OP_ADD, 32'h0, 32'h1);                  // counter wraps to zero
    send_item(OP_GET, 32'h0, 32'h1234_5678);
    send_item(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // insert through set
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_GET_HI, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_SET, 32'h0, 32'hA5A5_A5A5);          // overwrite on hit
    send_item(OP_GET, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'h5555_5555, 32'h0);
    send_item(OP_SET, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_GET, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'h1234_5678, 32'h0);          // miss, table not full
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    wait (hold_req == 1'b0);
    calm = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item(pick_op(), key_pool[$urandom_range(0, 7)], pick_value());
    calm = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_partial();
    logic [1:0] op;
    logic [31:0] k;
    for (int i = 0; i < 300; i++) begin
      calm = (i < 60);
      op = pick_op();
      k = key_pool[$urandom_range(0, 39)];
      // reads of unknown keys do not claim entries
      if ((op == OP_GET || op == OP_GET_HI) && $urandom_range(0, 4) == 0) k = $urandom;
      send_item(op, k, pick_value());
    end
    calm = 1'b0;
    wait_drain();
  endtask

  task automatic test_table_full();
    logic [31:0] fresh;
    while (shadow_used < ENTRIES)
      send_item($urandom_range(0, 1) ? OP_SET : OP_ADD, $urandom, pick_value());
    do fresh = $urandom; while (find_slot(fresh) >= 0);
    send_item(OP_ADD, fresh, 32'h1);                  // insert refused
    send_item(OP_SET, fresh, 32'hFFFF_FFFF);
    send_item(OP_GET, fresh, 32'h0);                  // miss on full table
    send_item(OP_GET_HI, fresh, 32'h0);
    send_item(OP_ADD, shadow_key[ENTRIES-1], 32'hFFFF_FFFF);
    send_item(OP_GET, shadow_key[ENTRIES-1], 32'h0);  // last entry of the scan
    send_item(OP_SET, shadow_key[0], 32'h0);
    send_item(OP_GET_HI, shadow_key[0], 32'h0);
    wait_drain();
  endtask

  task automatic test_random_full();
    logic [31:0] k;
    for (int i = 0; i < 1000; i++) begin
      calm = (i >= 400 && i < 550);
      if ($urandom_range(0, 9) < 7) k = shadow_key[$urandom_range(0, ENTRIES-1)];
      else k = $urandom;
      send_item(pick_op(), k, pick_value());
    end
    calm = 1'b0;
    wait_drain();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_basics();
    test_backpressure();
    test_random_partial();
    test_table_full();
    test_random_full();
    repeat (2 * ENTRIES + 20) @(posedge clk);
    if (fail_count == 0 && pending_tallies.size() == 0) begin
      $display("** keyed_counter_table_top: PASSED **");
    end else begin
      $display("** keyed_counter_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/kct_pkg.sv
sv/kct_ctrl.sv
sv/kct_datapath.sv
sv/keyed_counter_table_top.sv
tb/sv/testbench.sv
